>>> rtl/fhpc_pkg.sv
// Shared constants and types for the frame header parser and checker.
package fhpc_pkg;

	localparam int unsigned HEADER_BYTES   = 36;
	localparam int unsigned COUNT_W        = 33;
	localparam int unsigned QUEUE_DEPTH    = 4;
	localparam int unsigned CFG_INDEX_W    = 2;
	localparam int unsigned CFG_DATA_W     = 32;
	localparam int unsigned OUT_DATA_W     = 240;

	localparam logic [CFG_INDEX_W-1:0] REG_MAGIC   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VERSION = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CODEC   = 2'd2;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_MAGIC   = 3'd2,
		ST_VERSION = 3'd3,
		ST_HDR_LEN = 3'd4,
		ST_SIZE    = 3'd5,
		ST_DIMS    = 3'd6,
		ST_CODEC   = 3'd7
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [15:0] protocol_version;
		logic [15:0] accepted_codec;
	} cfg_t;

	// geometry_codec_flags: width 63..48, height 47..32, codec 31..16, flags 15..0
	typedef struct packed {
		logic               fwd;
		logic               last;
		logic [7:0]         data;
		logic [COUNT_W-1:0] byte_count;
		logic [31:0]        magic_seen;
		logic [15:0]        version_seen;
		logic [15:0]        hdr_len_seen;
		logic [63:0]        frame_number;
		logic [63:0]        time_stamp;
		logic [63:0]        geom;
		logic [31:0]        stated_length;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [63:0] frame_number;
		logic [63:0] time_stamp;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [15:0] codec_code;
		logic [15:0] flag_bits;
		logic [31:0] stated_length;
	} result_t;

endpackage

>>> rtl/fhpc_front.sv
// Front end: byte counter, header capture and payload classification.
module fhpc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic            q_full,
	output logic            push,
	output fhpc_pkg::entry_t entry
);
	import fhpc_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [31:0]        magic_q;
	logic [15:0]        version_q;
	logic [15:0]        hdr_len_q;
	logic [63:0]        frame_q;
	logic [63:0]        ts_q;
	logic [63:0]        geom_q;
	logic [31:0]        len_q;

	logic [COUNT_W-1:0] count_d;
	logic [31:0]        magic_d;
	logic [15:0]        version_d;
	logic [15:0]        hdr_len_d;
	logic [63:0]        frame_d;
	logic [63:0]        ts_d;
	logic [63:0]        geom_d;
	logic [31:0]        len_d;
	logic               accept;
	logic               in_hdr;
	logic               fwd;
	logic [5:0]         pos;
	logic [COUNT_W-1:0] pay_end;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pos      = count_q[5:0];
	assign in_hdr   = count_q < COUNT_W'(HEADER_BYTES);
	assign pay_end  = {1'b0, len_q} + COUNT_W'(HEADER_BYTES);
	assign fwd      = !in_hdr && (count_q < pay_end);

	always_comb begin
		magic_d   = magic_q;
		version_d = version_q;
		hdr_len_d = hdr_len_q;
		frame_d   = frame_q;
		ts_d      = ts_q;
		geom_d    = geom_q;
		len_d     = len_q;
		if (in_hdr) begin
			if (pos < 6'd4) begin
				magic_d = {magic_q[23:0], in_byte};
			end else if (pos < 6'd6) begin
				version_d = {version_q[7:0], in_byte};
			end else if (pos < 6'd8) begin
				hdr_len_d = {hdr_len_q[7:0], in_byte};
			end else if (pos < 6'd16) begin
				frame_d = {frame_q[55:0], in_byte};
			end else if (pos < 6'd24) begin
				ts_d = {ts_q[55:0], in_byte};
			end else if (pos < 6'd32) begin
				geom_d = {geom_q[55:0], in_byte};
			end else begin
				len_d = {len_q[23:0], in_byte};
			end
		end
		count_d = (count_q != {COUNT_W{1'b1}}) ? count_q + COUNT_W'(1) : count_q;
	end

	assign push                = accept && (fwd || in_last);
	assign entry.fwd           = fwd;
	assign entry.last          = in_last;
	assign entry.data          = in_byte;
	assign entry.byte_count    = count_d;
	assign entry.magic_seen    = magic_d;
	assign entry.version_seen  = version_d;
	assign entry.hdr_len_seen  = hdr_len_d;
	assign entry.frame_number  = frame_d;
	assign entry.time_stamp    = ts_d;
	assign entry.geom          = geom_d;
	assign entry.stated_length = len_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			magic_q   <= '0;
			version_q <= '0;
			hdr_len_q <= '0;
			frame_q   <= '0;
			ts_q      <= '0;
			geom_q    <= '0;
			len_q     <= '0;
		end else if (accept) begin
			if (in_last) begin
				count_q   <= '0;
				magic_q   <= '0;
				version_q <= '0;
				hdr_len_q <= '0;
				frame_q   <= '0;
				ts_q      <= '0;
				geom_q    <= '0;
				len_q     <= '0;
			end else begin
				count_q   <= count_d;
				magic_q   <= magic_d;
				version_q <= version_d;
				hdr_len_q <= hdr_len_d;
				frame_q   <= frame_d;
				ts_q      <= ts_d;
				geom_q    <= geom_d;
				len_q     <= len_d;
			end
		end
	end

endmodule

>>> rtl/fhpc_queue.sv
// Small register queue between front end and back end.
module fhpc_queue #(
	parameter int unsigned DEPTH = fhpc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fhpc_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output fhpc_pkg::entry_t rd_entry
);
	import fhpc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/fhpc_back.sv
// Back end: verdict checks and result output register.
module fhpc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fhpc_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  fhpc_pkg::entry_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output fhpc_pkg::result_t out_res
);
	import fhpc_pkg::*;

	logic    valid_q;
	logic    half_q;
	result_t res_q;
	result_t pay_res;
	result_t ver_res;
	status_t status;
	logic    can_load;
	logic    load;
	logic    split;
	logic [COUNT_W-1:0] total;

	assign total = {1'b0, head.stated_length} + COUNT_W'(HEADER_BYTES);

	always_comb begin
		if (head.byte_count < COUNT_W'(HEADER_BYTES)) begin
			status = ST_SHORT;
		end else if (head.magic_seen != cfg.magic_word) begin
			status = ST_MAGIC;
		end else if (head.version_seen != cfg.protocol_version) begin
			status = ST_VERSION;
		end else if (head.hdr_len_seen != 16'(HEADER_BYTES)) begin
			status = ST_HDR_LEN;
		end else if (head.byte_count != total) begin
			status = ST_SIZE;
		end else if (head.geom[63:48] == '0 || head.geom[47:32] == '0) begin
			status = ST_DIMS;
		end else if (head.geom[31:16] != cfg.accepted_codec) begin
			status = ST_CODEC;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		pay_res              = '0;
		pay_res.kind         = KIND_PAYLOAD;
		pay_res.payload_byte = head.data;
		pay_res.status       = ST_OK;

		ver_res               = '0;
		ver_res.kind          = KIND_VERDICT;
		ver_res.status        = status;
		ver_res.frame_number  = head.frame_number;
		ver_res.time_stamp    = head.time_stamp;
		ver_res.frame_width   = head.geom[63:48];
		ver_res.frame_height  = head.geom[47:32];
		ver_res.codec_code    = head.geom[31:16];
		ver_res.flag_bits     = head.geom[15:0];
		ver_res.stated_length = head.stated_length;
	end

	// a payload byte that ends the buffer yields two results: byte, then verdict
	assign can_load  = !valid_q || out_ready;
	assign load      = can_load && !q_empty;
	assign split     = head.fwd && head.last && !half_q;
	assign pop       = load && !split;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= (head.fwd && !half_q) ? pay_res : ver_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (can_load) begin
			valid_q <= !q_empty;
			if (load) begin
				half_q <= split;
			end
		end
	end

endmodule

>>> rtl/frame_header_parser_checker_core.sv
// Top level of the frame header parser and checker.
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata byte, tlast end of buffer
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata fields, tuser kind
//  cfg      | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One byte accepted per cycle while the queue is not full; the front end updates the header capture in the same cycle.
// A last byte that is also payload yields two output results (byte, then verdict).
// Queue between front and back absorbs output stalls; s_axis_tready drops when it is full.
// Reset clears all buffer state and config registers to zero; cfg_ready is always high.
module frame_header_parser_checker_core #(
	parameter int unsigned QUEUE_DEPTH = fhpc_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] byte_value
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] payload_byte, [10:8] status, [74:11] frame_number, [138:75] time_stamp,
	// [154:139] frame_width, [170:155] frame_height, [186:171] codec_code,
	// [202:187] flag_bits, [234:203] stated_length, [239:235] zero
	output logic [fhpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tuser,  // [0] kind
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fhpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fhpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fhpc_pkg::*;

	cfg_t    cfg_q;
	entry_t  wr_entry;
	entry_t  head;
	result_t res;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAGIC:   cfg_q.magic_word       <= cfg_data;
				REG_VERSION: cfg_q.protocol_version <= cfg_data[15:0];
				REG_CODEC:   cfg_q.accepted_codec   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	fhpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	fhpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.rd_entry (head)
	);

	fhpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tuser = res.kind;
	assign m_axis_tdata = {5'd0, res.stated_length, res.flag_bits, res.codec_code,
		res.frame_height, res.frame_width, res.time_stamp, res.frame_number,
		res.status, res.payload_byte};

endmodule
